// ----- design/lzwbse_pkg.sv -----
// lzwbse_pkg: word types and fixed constants for the lzw byte stream encoder
// no dependencies; used by lzw_byte_stream_encoder
package lzwbse_pkg;

    localparam int SYMBOL_BITS   = 8;
    localparam int MAX_CODE_BITS = 12;
    localparam int COUNT_BITS    = 24;
    localparam int CODE_W        = MAX_CODE_BITS + 1;
    localparam int DICT_SIZE     = (1 << MAX_CODE_BITS) + 1;

    localparam logic [CODE_W-1:0] DICT_RESET_CODE = CODE_W'(1 << SYMBOL_BITS);
    localparam logic [CODE_W-1:0] END_CODE   = CODE_W'((1 << SYMBOL_BITS) + 1);
    localparam logic [CODE_W-1:0] FIRST_FREE = CODE_W'((1 << SYMBOL_BITS) + 2);
    localparam logic [CODE_W-1:0] GROW_INIT  = CODE_W'(1 << (SYMBOL_BITS + 1));
    localparam logic [3:0]        MIN_WIDTH  = 4'(SYMBOL_BITS + 1);
    localparam logic [3:0]        MAX_WIDTH  = 4'(MAX_CODE_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] CAP_RESET = COUNT_BITS'(65536);

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] data_byte;
        logic                   last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0]            out_byte;
        logic                  end_of_block;
        logic                  status;
        logic [COUNT_BITS-1:0] total_length;
    } out_word_t;

endpackage

// ----- design/lzw_byte_stream_encoder.sv -----
// lzw_byte_stream_encoder: gif-style lzw compressor, 9 to 12 bit codes packed lsb first
// depends on lzwbse_pkg (word types, code constants)
//
// channel  | handshake                 | word
// ---------+---------------------------+-------------------------------------------
// in       | in_valid / in_ready       | data_byte, last_byte
// out      | out_valid / out_ready     | out_byte, end_of_block, status, total_length
// cfg      | cfg_wr_en                 | cfg_wr_data (output capacity)
//
// a byte that extends the match takes the child lookup and one walk step per sibling
// visited; a miss adds the miss state (and rebuild at full width), the final byte the
// last, last2, end and total states; the output register drains one word per cycle.
// the dictionary is checked against the free code and parent links, so no clearing
// pass follows reset; in_ready is high only between words, out stalls hold the drain.
module lzw_byte_stream_encoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lzwbse_pkg::in_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output lzwbse_pkg::out_word_t out_word,
    input  logic                cfg_wr_en,
    input  logic [lzwbse_pkg::COUNT_BITS-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_SCHK, S_FC, S_WALK, S_MISS, S_REBUILD,
        S_LAST, S_LAST2, S_END, S_TOT, S_OVF, S_DRAIN
    } state_t;

    typedef struct packed {
        logic [lzwbse_pkg::MAX_CODE_BITS-1:0] parent;
        logic [lzwbse_pkg::SYMBOL_BITS-1:0]   ch;
        logic [lzwbse_pkg::CODE_W-1:0]        sib;
    } entry_t;

    state_t state_reg;
    logic [lzwbse_pkg::COUNT_BITS-1:0]    cap_reg;
    logic [lzwbse_pkg::MAX_CODE_BITS-1:0] cur_reg;
    logic                                 open_reg;
    logic [lzwbse_pkg::CODE_W-1:0]        free_reg;
    logic [lzwbse_pkg::CODE_W-1:0]        grow_reg;
    logic [3:0]                           width_reg;
    logic [7:0]                           buf_reg;
    logic [2:0]                           fill_reg;
    logic [lzwbse_pkg::COUNT_BITS-1:0]    bw_reg;
    logic                                 aborted_reg;
    logic [lzwbse_pkg::SYMBOL_BITS-1:0]   ch_reg;
    logic                                 last_reg;
    logic [lzwbse_pkg::CODE_W-1:0]        walk_k_reg;
    logic                                 first_reg;
    logic [lzwbse_pkg::CODE_W-1:0]        fcv_reg;
    logic [7:0]                           obuf_reg [8];
    logic [2:0]                           ocnt_reg;
    logic [2:0]                           rd_reg;
    logic                                 final_reg;
    logic                                 status_reg;
    logic [lzwbse_pkg::COUNT_BITS-1:0]    total_reg;
    logic                                 out_valid_reg;
    lzwbse_pkg::out_word_t                out_word_reg;

    logic [lzwbse_pkg::CODE_W-1:0] child_mem [lzwbse_pkg::DICT_SIZE];
    entry_t                        entry_mem [lzwbse_pkg::DICT_SIZE];
    logic [lzwbse_pkg::CODE_W-1:0] fc_q;
    entry_t                        ent_q;
    logic [lzwbse_pkg::CODE_W-1:0] ent_raddr;
    logic                          mem_we;

    logic                          cap_hit;
    logic                          do_put;
    logic [lzwbse_pkg::CODE_W-1:0] put_code;
    logic [3:0]                    put_width;
    logic [23:0]                   acc;
    logic [4:0]                    put_n;
    logic [1:0]                    put_nb;
    logic [7:0]                    put_buf;
    logic [lzwbse_pkg::COUNT_BITS:0] bw_sum;
    logic [lzwbse_pkg::COUNT_BITS-1:0] bw_sat;
    logic [lzwbse_pkg::COUNT_BITS:0] tot_sum;
    logic [lzwbse_pkg::COUNT_BITS-1:0] tot_sat;
    logic                          drain_last;
    logic                          out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cap_hit   = (bw_reg >= cap_reg);

    always_comb
    begin
        put_code  = lzwbse_pkg::DICT_RESET_CODE;
        put_width = width_reg;
        do_put    = 1'b0;
        unique case (state_reg)
            S_START:
            begin
                put_width = lzwbse_pkg::MIN_WIDTH;
                do_put    = 1'b1;
            end
            S_SCHK:
            begin
                put_code = lzwbse_pkg::CODE_W'(ch_reg);
                do_put   = !cap_hit;
            end
            S_MISS:
            begin
                put_code = lzwbse_pkg::CODE_W'(cur_reg);
                do_put   = !cap_hit;
            end
            S_REBUILD: do_put = 1'b1;
            S_LAST:
            begin
                put_code = lzwbse_pkg::CODE_W'(cur_reg);
                do_put   = !cap_hit;
            end
            S_LAST2:
            begin
                put_code = lzwbse_pkg::CODE_W'(ch_reg);
                do_put   = 1'b1;
            end
            S_END:
            begin
                put_code = lzwbse_pkg::END_CODE;
                do_put   = 1'b1;
            end
            default: do_put = 1'b0;
        endcase
    end

    // bit packer: at most two whole bytes per code
    always_comb
    begin
        acc    = {16'b0, buf_reg} | (24'(put_code) << fill_reg);
        put_n  = 5'(fill_reg) + 5'(put_width);
        put_nb = put_n[4] ? 2'd2 : (put_n[3] ? 2'd1 : 2'd0);
        case (put_nb)
            2'd2:    put_buf = acc[23:16];
            2'd1:    put_buf = acc[15:8];
            default: put_buf = acc[7:0];
        endcase
        bw_sum  = {1'b0, bw_reg} + (lzwbse_pkg::COUNT_BITS + 1)'(put_nb);
        bw_sat  = (bw_sum > {1'b0, lzwbse_pkg::COUNT_MAX}) ? lzwbse_pkg::COUNT_MAX
                                                           : bw_sum[lzwbse_pkg::COUNT_BITS-1:0];
        tot_sum = {1'b0, bw_reg} + (lzwbse_pkg::COUNT_BITS + 1)'(fill_reg != 3'd0);
        tot_sat = (tot_sum > {1'b0, lzwbse_pkg::COUNT_MAX}) ? lzwbse_pkg::COUNT_MAX
                                                            : tot_sum[lzwbse_pkg::COUNT_BITS-1:0];
    end

    assign ent_raddr  = (state_reg == S_FC) ? fc_q : ent_q.sib;
    assign mem_we     = (state_reg == S_MISS) && !cap_hit;
    assign drain_last = (rd_reg == ocnt_reg - 3'd1);
    assign out_load   = (state_reg == S_DRAIN) && (rd_reg != ocnt_reg)
                        && (!out_valid_reg || out_ready);

    // dictionary memories
    always_ff @(posedge clk)
    begin
        fc_q  <= child_mem[lzwbse_pkg::CODE_W'(cur_reg)];
        ent_q <= entry_mem[ent_raddr];
        if (mem_we)
        begin
            child_mem[lzwbse_pkg::CODE_W'(cur_reg)] <= free_reg;
            entry_mem[free_reg] <= '{parent: cur_reg, ch: ch_reg, sib: fcv_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= lzwbse_pkg::CAP_RESET;
            cur_reg       <= '0;
            open_reg      <= 1'b0;
            free_reg      <= lzwbse_pkg::FIRST_FREE;
            grow_reg      <= lzwbse_pkg::GROW_INIT;
            width_reg     <= lzwbse_pkg::MIN_WIDTH;
            buf_reg       <= '0;
            fill_reg      <= '0;
            bw_reg        <= '0;
            aborted_reg   <= 1'b0;
            ch_reg        <= '0;
            last_reg      <= 1'b0;
            walk_k_reg    <= '0;
            first_reg     <= 1'b0;
            fcv_reg       <= '0;
            for (int i = 0; i < 8; i++)
            begin
                obuf_reg[i] <= '0;
            end
            ocnt_reg      <= '0;
            rd_reg        <= '0;
            final_reg     <= 1'b0;
            status_reg    <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_put)
            begin
                if (put_nb != 2'd0)
                begin
                    obuf_reg[ocnt_reg] <= acc[7:0];
                end
                if (put_nb == 2'd2)
                begin
                    obuf_reg[ocnt_reg + 3'd1] <= acc[15:8];
                end
                ocnt_reg <= ocnt_reg + 3'(put_nb);
                buf_reg  <= put_buf;
                fill_reg <= put_n[2:0];
                bw_reg   <= bw_sat;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        ch_reg     <= in_word.data_byte;
                        last_reg   <= in_word.last_byte;
                        ocnt_reg   <= '0;
                        rd_reg     <= '0;
                        final_reg  <= 1'b0;
                        status_reg <= 1'b0;
                        total_reg  <= '0;
                        if (aborted_reg)
                        begin
                            state_reg <= in_word.last_byte ? S_OVF : S_IDLE;
                        end
                        else if (!open_reg)
                        begin
                            width_reg <= lzwbse_pkg::MIN_WIDTH;
                            state_reg <= S_START;
                        end
                        else
                        begin
                            state_reg <= in_word.last_byte ? S_LAST : S_FC;
                        end
                    end
                end
                S_START:
                begin
                    free_reg <= lzwbse_pkg::FIRST_FREE;
                    grow_reg <= lzwbse_pkg::GROW_INIT;
                    if (!last_reg)
                    begin
                        cur_reg   <= lzwbse_pkg::MAX_CODE_BITS'(ch_reg);
                        open_reg  <= 1'b1;
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        state_reg <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    state_reg <= cap_hit ? S_OVF : S_END;
                end
                S_FC:
                begin
                    if (fc_q >= lzwbse_pkg::FIRST_FREE && fc_q < free_reg)
                    begin
                        walk_k_reg <= fc_q;
                        first_reg  <= 1'b1;
                        state_reg  <= S_WALK;
                    end
                    else
                    begin
                        fcv_reg   <= '0;
                        state_reg <= S_MISS;
                    end
                end
                S_WALK:
                begin
                    if (first_reg && ent_q.parent != cur_reg)
                    begin
                        fcv_reg   <= '0;
                        state_reg <= S_MISS;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            fcv_reg <= walk_k_reg;
                        end
                        first_reg <= 1'b0;
                        if (ent_q.ch == ch_reg)
                        begin
                            cur_reg   <= walk_k_reg[lzwbse_pkg::MAX_CODE_BITS-1:0];
                            state_reg <= S_DRAIN;
                        end
                        else if (ent_q.sib == '0)
                        begin
                            state_reg <= S_MISS;
                        end
                        else
                        begin
                            walk_k_reg <= ent_q.sib;
                        end
                    end
                end
                S_MISS:
                begin
                    if (cap_hit)
                    begin
                        aborted_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        free_reg  <= free_reg + 1'b1;
                        cur_reg   <= lzwbse_pkg::MAX_CODE_BITS'(ch_reg);
                        state_reg <= S_DRAIN;
                        if (free_reg >= grow_reg)
                        begin
                            grow_reg <= grow_reg << 1;
                            if (width_reg < lzwbse_pkg::MAX_WIDTH)
                            begin
                                width_reg <= width_reg + 4'd1;
                            end
                            else
                            begin
                                state_reg <= S_REBUILD;
                            end
                        end
                    end
                end
                S_REBUILD:
                begin
                    width_reg <= lzwbse_pkg::MIN_WIDTH;
                    free_reg  <= lzwbse_pkg::FIRST_FREE;
                    grow_reg  <= lzwbse_pkg::GROW_INIT;
                    state_reg <= S_DRAIN;
                end
                S_LAST:
                begin
                    state_reg <= cap_hit ? S_OVF : S_LAST2;
                end
                S_LAST2:
                begin
                    state_reg <= S_END;
                end
                S_END:
                begin
                    state_reg <= S_TOT;
                end
                S_TOT:
                begin
                    if (tot_sat >= cap_reg)
                    begin
                        state_reg <= S_OVF;
                    end
                    else
                    begin
                        if (fill_reg != 3'd0)
                        begin
                            obuf_reg[ocnt_reg] <= buf_reg;
                            ocnt_reg           <= ocnt_reg + 3'd1;
                        end
                        final_reg   <= 1'b1;
                        total_reg   <= tot_sat;
                        open_reg    <= 1'b0;
                        cur_reg     <= '0;
                        buf_reg     <= '0;
                        fill_reg    <= '0;
                        bw_reg      <= '0;
                        aborted_reg <= 1'b0;
                        state_reg   <= S_DRAIN;
                    end
                end
                S_OVF:
                begin
                    obuf_reg[0] <= '0;
                    ocnt_reg    <= 3'd1;
                    final_reg   <= 1'b1;
                    status_reg  <= 1'b1;
                    total_reg   <= '0;
                    open_reg    <= 1'b0;
                    cur_reg     <= '0;
                    buf_reg     <= '0;
                    fill_reg    <= '0;
                    bw_reg      <= '0;
                    aborted_reg <= 1'b0;
                    state_reg   <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (rd_reg == ocnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_load)
                    begin
                        out_word_reg.out_byte     <= obuf_reg[rd_reg];
                        out_word_reg.end_of_block <= final_reg && drain_last;
                        out_word_reg.status       <= status_reg && final_reg && drain_last;
                        out_word_reg.total_length <= (final_reg && drain_last) ? total_reg : '0;
                        rd_reg                    <= rd_reg + 3'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
